[rtl/core/crsf_pkg.sv]
// Shared types and constants for the CRSF RC-channels frame parser.
// No dependencies; crsf_dp, crsf_ctrl and the top level import this package.
package crsf_pkg;

  localparam logic [7:0] SYNC_ADDR_RST = 8'hC8;
  localparam logic [7:0] RC_FRAME_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;
  localparam int         PAYLOAD_BYTES = 22;
  localparam int         PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int         CHAN_BITS     = 11;
  localparam logic [5:0] RC_LENGTH     = 6'(PAYLOAD_BYTES + 2);

  // result status codes
  localparam logic [1:0] ST_CHANNEL = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start_frame; // length byte good: load length, clear position and CRC
    logic body_byte;   // type or payload byte
    logic end_byte;    // CRC byte: check and count
    logic emit;        // load one result into the output register
  } crsf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic addr_match;
    logic len_ok;
    logic body_end;
    logic out_free;
    logic emit_last;
  } crsf_sts_t;

endpackage

[rtl/core/crsf_intf.sv]
// Channel interfaces for the CRSF parser: input byte, result and config write.
// Depends on nothing; ports follow a valid/ready handshake.
interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;
  logic [31:0] good_frames;
  logic [31:0] crc_errors;

  modport source (output valid, output status, output channel_index,
                  output channel_value, output last, output good_frames,
                  output crc_errors, input ready);
  modport sink   (input valid, input status, input channel_index,
                  input channel_value, input last, input good_frames,
                  input crc_errors, output ready);
endinterface

interface crsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sync_address;

  modport source (output valid, output sync_address, input ready);
  modport sink   (input valid, input sync_address, output ready);
endinterface

[rtl/core/crsf_dp.sv]
// Datapath of the CRSF parser: CRC, payload shift store, counters, result register.
// Depends on crsf_pkg and the crsf_out_if / crsf_cfg_if interfaces.
module crsf_dp #(
  parameter int NUM_CHANNELS = 16,
  parameter int MAX_LENGTH   = 62
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          rx_byte,
  input  crsf_pkg::crsf_cmd_t cmd,
  output crsf_pkg::crsf_sts_t sts,
  crsf_cfg_if.sink            cfg,
  crsf_out_if.source          res
);
  import crsf_pkg::*;

  localparam logic [3:0] LastChan = 4'(NUM_CHANNELS - 1);
  localparam logic [7:0] MaxLen   = 8'(MAX_LENGTH);

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]           sync_addr_r;
  logic [5:0]           frame_len_r;
  logic [5:0]           pos_r;
  logic [7:0]           crc_r;
  logic [7:0]           type_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [31:0]          good_cnt_r;
  logic [31:0]          err_cnt_r;
  logic [1:0]           kind_r;
  logic [3:0]           chan_cnt_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_index_r;
  logic [10:0]          out_value_r;
  logic                 out_last_r;
  logic [31:0]          out_good_r;
  logic [31:0]          out_err_r;

  logic crc_ok;
  logic rc_frame;

  assign crc_ok   = (rx_byte == crc_r);
  assign rc_frame = (type_r == RC_FRAME_TYPE) && (frame_len_r == RC_LENGTH);

  assign sts.addr_match = (rx_byte == sync_addr_r);
  assign sts.len_ok     = (rx_byte >= MIN_LENGTH) && (rx_byte <= MaxLen);
  assign sts.body_end   = ({1'b0, pos_r} + 7'd1) >= {1'b0, frame_len_r};
  assign sts.out_free   = !out_valid_r || res.ready;
  assign sts.emit_last  = (kind_r != ST_CHANNEL) || (chan_cnt_r == LastChan);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_addr_r <= SYNC_ADDR_RST;
    end else if (cfg.valid) begin
      sync_addr_r <= cfg.sync_address;
    end
  end

  // frame tracking and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= '0;
      pos_r       <= '0;
      crc_r       <= '0;
      type_r      <= '0;
      good_cnt_r  <= '0;
      err_cnt_r   <= '0;
      kind_r      <= ST_IGNORED;
      chan_cnt_r  <= '0;
    end else begin
      if (cmd.start_frame) begin
        frame_len_r <= rx_byte[5:0];
        pos_r       <= '0;
        crc_r       <= '0;
      end
      if (cmd.body_byte) begin
        if (pos_r == 6'd0) begin
          type_r <= rx_byte;
        end
        crc_r <= crc8_update(crc_r, rx_byte);
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.end_byte) begin
        pos_r      <= '0;
        chan_cnt_r <= '0;
        if (!crc_ok) begin
          err_cnt_r <= err_cnt_r + 32'd1;
          kind_r    <= ST_CRC_ERR;
        end else if (rc_frame) begin
          good_cnt_r <= good_cnt_r + 32'd1;
          kind_r     <= ST_CHANNEL;
        end else begin
          kind_r <= ST_IGNORED;
        end
      end
      if (cmd.emit && kind_r == ST_CHANNEL) begin
        chan_cnt_r <= chan_cnt_r + 4'd1;
      end
    end
  end

  // payload store: bytes enter at the top, channels leave at the bottom
  always_ff @(posedge clk) begin
    if (cmd.body_byte && pos_r != 6'd0 && pos_r <= 6'(PAYLOAD_BYTES)) begin
      payload_r <= {rx_byte, payload_r[PAYLOAD_W-1:8]};
    end else if (cmd.emit && kind_r == ST_CHANNEL) begin
      payload_r <= {{CHAN_BITS{1'b0}}, payload_r[PAYLOAD_W-1:CHAN_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= kind_r;
      out_good_r   <= good_cnt_r;
      out_err_r    <= err_cnt_r;
      if (kind_r == ST_CHANNEL) begin
        out_index_r <= chan_cnt_r;
        out_value_r <= payload_r[CHAN_BITS-1:0];
        out_last_r  <= (chan_cnt_r == LastChan);
      end else begin
        out_index_r <= '0;
        out_value_r <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign res.valid         = out_valid_r;
  assign res.status        = out_status_r;
  assign res.channel_index = out_index_r;
  assign res.channel_value = out_value_r;
  assign res.last          = out_last_r;
  assign res.good_frames   = out_good_r;
  assign res.crc_errors    = out_err_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_good_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.end_byte && crc_ok && rc_frame) |=> good_cnt_r == $past(good_cnt_r) + 32'd1)
    else $error("good frame count missed an increment");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.end_byte |=> ($stable(good_cnt_r) && $stable(err_cnt_r)))
    else $error("frame counters moved outside a frame end");

endmodule

[rtl/core/crsf_ctrl.sv]
// Controller of the CRSF parser: frame phase state machine and result sequencing.
// Depends on crsf_pkg; talks to crsf_dp through command and status structs.
module crsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crsf_pkg::crsf_sts_t sts,
  output crsf_pkg::crsf_cmd_t cmd
);
  import crsf_pkg::*;

  typedef enum logic [3:0] {
    S_ADDR = 4'b0001,
    S_LEN  = 4'b0010,
    S_BODY = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r != S_EMIT);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    cmd.start_frame = 1'b0;
    cmd.body_byte   = 1'b0;
    cmd.end_byte    = 1'b0;
    cmd.emit        = 1'b0;
    unique case (state_r)
      S_ADDR: begin
        if (acc && sts.addr_match) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (acc) begin
          if (sts.len_ok) begin
            cmd.start_frame = 1'b1;
            state_nxt       = S_BODY;
          end else begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          if (sts.body_end) begin
            cmd.end_byte = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.body_byte = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_ADDR;
        end
      end
      default: state_nxt = S_ADDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ADDR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start_frame, cmd.body_byte, cmd.end_byte, cmd.emit}))
    else $error("more than one datapath command at once");

  a_end_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_byte |=> (state_r == S_EMIT && !in_ready))
    else $error("frame end did not enter result phase");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> state_r == S_ADDR)
    else $error("result phase did not close after last result");

endmodule

[rtl/core/crsf_rc_frame_parser.sv]
// CRSF RC-channels frame parser, top level.
// Results: a frame's first result is registered in the result phase after its CRC byte,
// once the output register is free; further channel words follow one a cycle while
// out ready is high. Throughput: one byte per cycle inside a frame; input stalls
// after a CRC byte while its result words (NUM_CHANNELS, or one if error/ignored) drain.
// Reset (rst_n low, synchronous): wait for address, counters zero, sync address 0xC8.
module crsf_rc_frame_parser #(
  parameter int NUM_CHANNELS = 16, // channels emitted per RC frame, 1..16
  parameter int MAX_LENGTH   = 62  // largest accepted length byte, 2..62
) (
  input  logic       clk,
  input  logic       rst_n,
  crsf_in_if.sink    in_chan,
  crsf_out_if.source out_chan,
  crsf_cfg_if.sink   cfg_chan
);
  import crsf_pkg::*;

  // Controller owns the frame phase (address, length, body, result drain);
  // datapath owns the byte-level work: CRC-8, payload store, counters and the
  // output register that decouples result words from incoming bytes.
  crsf_cmd_t cmd;
  crsf_sts_t sts;

  crsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Payload bytes shift into a 176-bit store; on a good RC frame it shifts
  // out eleven bits per channel word, giving the LSB-first channel unpack.
  crsf_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_LENGTH   (MAX_LENGTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_chan.rx_byte),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg_chan),
    .res     (out_chan)
  );

endmodule
